// ----- design/oaht_pkg.sv -----
// shared types, codes and constants of the open-addressing hash table
// no dependencies; imported by the controller, the datapath and the top module
package oaht_pkg;

   // field widths of one item
   localparam int ACTION_W    = 2;
   localparam int KEY_W       = 32;
   localparam int HASH_W      = 32;
   localparam int VALUE_W     = 64;
   localparam int STATUS_W    = 2;
   localparam int MAX_COUNT_W = 8;
   localparam int USED_W      = 9;

   // steps of the hash remainder when the slot count is not a power of two
   localparam int MOD_STEPS   = 3;
   localparam int MOD_CNT_W   = 2;

   // defaults
   localparam int DEF_TABLE_SLOTS = 256;
   localparam logic [MAX_COUNT_W-1:0] MAX_COUNT_RESET = 8'd192;

   // operation codes
   typedef enum logic [ACTION_W-1:0] {
      ACT_GET = 2'd0,
      ACT_SET = 2'd1,
      ACT_DEL = 2'd2
   } action_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_TRUE  = 2'd0,
      STAT_FALSE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // slot kinds
   typedef enum logic [1:0] {
      KIND_EMPTY = 2'd0,
      KIND_USED  = 2'd1,
      KIND_TOMB  = 2'd2
   } kind_type;

   // one slot as kept in the slot memory
   typedef struct packed {
      kind_type             kind;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   // controller states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_START,
      S_PROBE,
      S_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic clr_step;
      logic load_item;
      logic mod_step;
      logic start;
      logic probe;
      logic rsp_load;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clr_last;
      logic need_mod;
      logic mod_last;
      logic early_stop;
      logic probe_stop;
      logic rsp_free;
   } stat_type;

endpackage

// ----- design/oaht_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module oaht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/oaht_ctrl.sv -----
// controller state machine: clear pass, item intake, home index, probe walk, result hand-off
// depends on oaht_pkg
module oaht_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  oaht_pkg::stat_type stat,
   output oaht_pkg::cmd_type  cmd
);
   import oaht_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = stat.need_mod ? S_MOD : S_START;
         end
         S_MOD: begin
            if (stat.mod_last) state_in = S_START;
         end
         S_START: begin
            state_in = stat.early_stop ? S_DONE : S_PROBE;
         end
         S_PROBE: begin
            if (stat.probe_stop) state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: cmd.clr_step = 1'b1;
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         S_MOD:   cmd.mod_step = 1'b1;
         S_START: cmd.start    = 1'b1;
         S_PROBE: cmd.probe    = 1'b1;
         S_DONE:  cmd.rsp_load = stat.rsp_free;
         default: cmd = '0;
      endcase
   end

`ifndef SYNTHESIS
   // the clear pass runs once after reset only
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(state_ff) != S_CLEAR |-> state_ff != S_CLEAR)
      else $error("controller re-entered the clear pass");

   // a result is moved to the output register only when that register is free
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.rsp_free && state_ff == S_DONE)
      else $error("result loaded over a waiting result");

   // a new item is taken only while idle
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE)
      else $error("item taken outside the idle state");
`endif

endmodule

// ----- design/oaht_dp.sv -----
// datapath: item registers, home index reduction, probe walk, slot update, result registers
// depends on oaht_pkg; drives the ports of the slot ram
module oaht_dp #(
   parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS,
   localparam int IDX_W = $clog2(TABLE_SLOTS)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  oaht_pkg::cmd_type                   cmd,
   output oaht_pkg::stat_type                  stat,
   input  logic [oaht_pkg::ACTION_W-1:0]       req_action,
   input  logic [oaht_pkg::KEY_W-1:0]          req_key_id,
   input  logic [oaht_pkg::HASH_W-1:0]         req_key_hash,
   input  logic [oaht_pkg::VALUE_W-1:0]        req_value_in,
   input  logic                                csr_wr_en,
   input  logic [oaht_pkg::MAX_COUNT_W-1:0]    csr_wr_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [oaht_pkg::STATUS_W-1:0]       rsp_status,
   output logic [oaht_pkg::VALUE_W-1:0]        rsp_value_out,
   output logic                                ram_wr_en,
   output logic [IDX_W-1:0]                    ram_wr_addr,
   output logic [oaht_pkg::SLOT_W-1:0]         ram_wr_data,
   output logic [IDX_W-1:0]                    ram_rd_addr,
   input  logic [oaht_pkg::SLOT_W-1:0]         ram_rd_data
);
   import oaht_pkg::*;

   localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_SLOTS - 1);
   localparam logic [IDX_W-1:0] SLOTS_LOW  = IDX_W'(TABLE_SLOTS);
   // rounded-up reciprocal of the slot count, quotient is exact for every 32-bit hash
   localparam logic [HASH_W-1:0] RECIP =
      HASH_W'(((((64'd1 << IDX_W) - 64'(TABLE_SLOTS)) << HASH_W) / 64'(TABLE_SLOTS))
              + 64'd1);

   // control registers
   logic [IDX_W-1:0]       clr_idx_ff, clr_idx_in;
   logic [USED_W-1:0]      used_count_ff, used_count_in;
   logic [MAX_COUNT_W-1:0] max_count_ff, max_count_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [ACTION_W-1:0]    action_ff, action_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [HASH_W-1:0]      hash_ff, hash_in;
   logic [VALUE_W-1:0]     val_ff, val_in;
   logic [HASH_W-1:0]      quot_ff, quot_in;
   logic [IDX_W-1:0]       rem_ff, rem_in;
   logic [MOD_CNT_W-1:0]   mod_cnt_ff, mod_cnt_in;
   logic [IDX_W-1:0]       cur_ff, cur_in;
   logic [IDX_W-1:0]       cnt_ff, cnt_in;
   logic                   tomb_ff, tomb_in;
   logic [IDX_W-1:0]       tomb_at_ff, tomb_at_in;
   status_type             res_status_ff, res_status_in;
   logic [VALUE_W-1:0]     res_value_ff, res_value_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]     rsp_value_ff, rsp_value_in;

   logic [2*HASH_W-1:0]    recip_prod;
   logic [IDX_W-1:0]       rem_prod;
   logic [IDX_W-1:0]       home_idx;
   logic [IDX_W-1:0]       next_idx;
   slot_type               rd_slot;
   slot_type               wr_slot;
   logic                   is_empty, is_tomb, is_hit, is_last, probe_stop;
   logic                   tomb_seen;
   logic [IDX_W-1:0]       tomb_addr;
   logic                   early_full, bad_action, early_stop;
   logic                   used_inc;

   // register update
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff    <= '0;
         used_count_ff <= '0;
         max_count_ff  <= MAX_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_idx_ff    <= clr_idx_in;
         used_count_ff <= used_count_in;
         max_count_ff  <= max_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      key_ff        <= key_in;
      hash_ff       <= hash_in;
      val_ff        <= val_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      mod_cnt_ff    <= mod_cnt_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      tomb_ff       <= tomb_in;
      tomb_at_ff    <= tomb_at_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // load limit register
   always_comb begin
      max_count_in = max_count_ff;
      if (csr_wr_en) max_count_in = csr_wr_data;
   end

   // clear pass counter
   always_comb begin
      clr_idx_in = clr_idx_ff;
      if (cmd.clr_step) clr_idx_in = clr_idx_ff + 1'b1;
   end

   // item intake and remainder of the hash by the slot count:
   // high half of the reciprocal product, then the quotient, then hash minus quotient times slots
   assign recip_prod = (2*HASH_W)'(hash_ff) * (2*HASH_W)'(RECIP);
   assign rem_prod   = quot_ff[IDX_W-1:0] * SLOTS_LOW;

   always_comb begin
      action_in  = action_ff;
      key_in     = key_ff;
      hash_in    = hash_ff;
      val_in     = val_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      mod_cnt_in = mod_cnt_ff;
      if (cmd.load_item) begin
         action_in  = req_action;
         key_in     = req_key_id;
         hash_in    = req_key_hash;
         val_in     = req_value_in;
         rem_in     = '0;
         mod_cnt_in = '0;
      end else if (cmd.mod_step) begin
         case (mod_cnt_ff)
            MOD_CNT_W'(0): quot_in = recip_prod[2*HASH_W-1:HASH_W];
            MOD_CNT_W'(1): quot_in = (quot_ff + ((hash_ff - quot_ff) >> 1)) >> (IDX_W - 1);
            default:       rem_in  = hash_ff[IDX_W-1:0] - rem_prod;
         endcase
         mod_cnt_in = mod_cnt_ff + 1'b1;
      end
   end

   assign home_idx = IS_POW2 ? hash_ff[IDX_W-1:0] : rem_ff;

   // refusals decided before any probe
   assign early_full = (action_ff == ACT_SET) &&
                       (({1'b0, used_count_ff} + 10'd1) > {2'b00, max_count_ff});
   assign bad_action = (action_ff != ACT_GET) && (action_ff != ACT_SET) &&
                       (action_ff != ACT_DEL);
   assign early_stop = early_full || bad_action;

   // slot evaluation for the slot read in the previous cycle
   assign rd_slot    = slot_type'(ram_rd_data);
   assign is_empty   = rd_slot.kind == KIND_EMPTY;
   assign is_tomb    = rd_slot.kind == KIND_TOMB;
   assign is_hit     = !is_empty && !is_tomb && (rd_slot.key == key_ff);
   assign is_last    = cnt_ff == LAST_IDX;
   assign probe_stop = is_empty || is_hit || is_last;
   assign tomb_seen  = tomb_ff || is_tomb;
   assign tomb_addr  = tomb_ff ? tomb_at_ff : cur_ff;
   assign next_idx   = (cur_ff == LAST_IDX) ? '0 : cur_ff + 1'b1;

   // probe walk, one slot a cycle
   always_comb begin
      cur_in      = cur_ff;
      cnt_in      = cnt_ff;
      tomb_in     = tomb_ff;
      tomb_at_in  = tomb_at_ff;
      ram_rd_addr = next_idx;
      if (cmd.start) begin
         ram_rd_addr = home_idx;
         cur_in      = home_idx;
         cnt_in      = '0;
         tomb_in     = 1'b0;
      end else if (cmd.probe && !probe_stop) begin
         cur_in = next_idx;
         cnt_in = cnt_ff + 1'b1;
         if (is_tomb && !tomb_ff) begin
            tomb_in    = 1'b1;
            tomb_at_in = cur_ff;
         end
      end
   end

   // outcome of the item and slot update
   always_comb begin
      res_status_in  = res_status_ff;
      res_value_in   = res_value_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = clr_idx_ff;
      wr_slot.kind   = KIND_EMPTY;
      wr_slot.key    = '0;
      wr_slot.value  = '0;
      used_inc       = 1'b0;
      if (cmd.clr_step) begin
         ram_wr_en = 1'b1;
      end else if (cmd.start && early_stop) begin
         res_status_in = early_full ? STAT_FULL : STAT_FALSE;
         res_value_in  = '0;
      end else if (cmd.probe && probe_stop) begin
         res_status_in = STAT_FALSE;
         res_value_in  = '0;
         wr_slot.kind  = KIND_USED;
         wr_slot.key   = key_ff;
         wr_slot.value = val_ff;
         ram_wr_addr   = cur_ff;
         case (action_ff)
            ACT_GET: begin
               if (is_hit) begin
                  res_status_in = STAT_TRUE;
                  res_value_in  = rd_slot.value;
               end
            end
            ACT_SET: begin
               if (is_hit) begin
                  ram_wr_en     = 1'b1;
                  res_status_in = STAT_FALSE;
               end else if (tomb_seen) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = tomb_addr;
                  res_status_in = STAT_TRUE;
               end else if (is_empty) begin
                  ram_wr_en     = 1'b1;
                  used_inc      = 1'b1;
                  res_status_in = STAT_TRUE;
               end else begin
                  res_status_in = STAT_FULL;
               end
            end
            ACT_DEL: begin
               if (is_hit) begin
                  ram_wr_en     = 1'b1;
                  wr_slot.kind  = KIND_TOMB;
                  wr_slot.key   = rd_slot.key;
                  wr_slot.value = rd_slot.value;
                  res_status_in = STAT_TRUE;
               end
            end
            default: res_status_in = STAT_FALSE;
         endcase
      end
   end

   assign ram_wr_data   = wr_slot;
   assign used_count_in = used_count_ff + USED_W'(used_inc);

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_value_in  = res_value_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;

   // status to the controller
   assign stat.clr_last   = clr_idx_ff == LAST_IDX;
   assign stat.need_mod   = !IS_POW2;
   assign stat.mod_last   = mod_cnt_ff == MOD_CNT_W'(MOD_STEPS - 1);
   assign stat.early_stop = early_stop;
   assign stat.probe_stop = probe_stop;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

`ifndef SYNTHESIS
   // only a successful get carries a value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STAT_TRUE |-> rsp_value_ff == '0)
      else $error("value on a result that found nothing");

   // used count never falls and grows by at most one per item
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> USED_W'(used_count_ff - $past(used_count_ff)) <= USED_W'(1))
      else $error("used count moved by more than one or fell");

   // outside the clear pass the slot store is written only where a probe ends
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && !cmd.clr_step |-> cmd.probe && probe_stop)
      else $error("slot written outside the end of a probe");
`endif

endmodule

// ----- design/open_addressing_hash_table_top.sv -----
// open-addressing hash table, linear probing with tombstones; one result per item
// accept, home index, probe walk of 1 to TABLE_SLOTS slots, then the result is registered;
// sets refused by the load limit and undefined actions skip the probe walk
// one item at a time; the probe walk does one read of the single slot memory per step;
// extra remainder steps when TABLE_SLOTS is not a power of two (reciprocal hash remainder)
// reset: synchronous; a clearing pass over every slot empties the slot store, no item taken
module open_addressing_hash_table_top #(
   parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [oaht_pkg::ACTION_W-1:0]     req_action,
   input  logic [oaht_pkg::KEY_W-1:0]        req_key_id,
   input  logic [oaht_pkg::HASH_W-1:0]       req_key_hash,
   input  logic [oaht_pkg::VALUE_W-1:0]      req_value_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [oaht_pkg::STATUS_W-1:0]     rsp_status,
   output logic [oaht_pkg::VALUE_W-1:0]      rsp_value_out,
   input  logic                              csr_wr_en,
   input  logic [oaht_pkg::MAX_COUNT_W-1:0]  csr_wr_data
);
   import oaht_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SLOTS);

   cmd_type           cmd;
   stat_type          stat;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [SLOT_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [SLOT_W-1:0] ram_rd_data;

   // controller
   oaht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   oaht_dp #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_action    (req_action),
      .req_key_id    (req_key_id),
      .req_key_hash  (req_key_hash),
      .req_value_in  (req_value_in),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data)
   );

   // slot store: kind, key and value per slot
   oaht_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
